// ----- rtl/core/scfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types, codes and command table of the serial command frame decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

    localparam int FRAME_LEN  = 7;
    localparam int BODY_LEN   = FRAME_LEN - 1;
    localparam int NUM_FIXED  = 14;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int VOL_W      = 10;
    localparam int MASK_W     = 17;

    localparam int BIT_VOL_UP   = 14;
    localparam int BIT_VOL_DOWN = 15;
    localparam int BIT_UNKNOWN  = 16;

    localparam logic [7:0] CHAR_START = 8'h2A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [VOL_W-1:0] VOL_DOWN_LOW = 10'd900;
    localparam logic [VOL_W-1:0] VOL_DOWN_OFS = 10'd899;

    localparam logic [31:0]       IDLE_TIMEOUT_RST = 32'd1000;
    localparam logic [VOL_W-1:0]  VOL_FLOOR_RST    = 10'd1;
    localparam logic [VOL_W-1:0]  VOL_CEIL_RST     = 10'd100;
    localparam logic [MASK_W-1:0] HANDLER_MASK_RST = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_IDLE_TIMEOUT = 3'd1,
        CFG_VOL_FLOOR    = 3'd2,
        CFG_VOL_CEIL     = 3'd3,
        CFG_HANDLER_MASK = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_CMD          = 3'd0,
        EV_CMD_NO_HDLR  = 3'd1,
        EV_VOL_UP       = 3'd2,
        EV_VOL_DOWN     = 3'd3,
        EV_UNKNOWN      = 3'd4,
        EV_UNKNOWN_NO_H = 3'd5
    } event_kind_t;

    typedef logic [BODY_LEN-1:0][7:0]  frame_body_t;
    typedef logic [FRAME_LEN*8-1:0]    frame_text_t;

    typedef struct packed {
        logic       stray;
        logic       full;
        logic [7:0] last_byte;
    } frame_status_t;

    typedef struct packed {
        logic             valid;
        event_kind_t      kind;
        logic [3:0]       index;
        logic [VOL_W-1:0] level;
    } event_t;

    localparam frame_text_t FIXED_CMDS [NUM_FIXED] = '{
        "*_ARM__", "*A_CLR1", "*A_CLR2", "*I_WAIL", "*CHEM_A", "*DISARM",
        "*CANCEL", "*Q_TEST", "*_WAIL_", "*P_WAIL", "*YELP__", "*REPORT",
        "*_VOICE", "*RESET_"
    };

    localparam logic [31:0] VOL_HEAD = "*VOL";

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

endpackage

// ----- rtl/core/scfd_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_frame
// Frame assembly: idle timeout, start check, byte store and frame count.
// ----------------------------------------------------------------------------
module scfd_frame
    import scfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [7:0]    byte_in,
    input  logic [31:0]   time_ms,
    input  logic          enable,
    input  logic [31:0]   idle_timeout,
    output frame_status_t status,
    output frame_body_t   body
);

    logic [CNT_W-1:0] frame_count_reg;
    logic [CNT_W-1:0] frame_count_next;
    logic [31:0]      last_time_reg;
    logic [7:0]       bytes_reg [BODY_LEN];

    logic [31:0]      gap;
    logic [CNT_W-1:0] cnt_eff;
    logic             take;
    logic             stray;
    logic             store;
    logic             full;

    assign gap     = time_ms - last_time_reg;
    assign cnt_eff = (frame_count_reg != '0 && gap > idle_timeout) ? '0 : frame_count_reg;
    assign take    = enable && (byte_in inside {[8'd32:8'd126]});
    assign stray   = take && cnt_eff == '0 && byte_in != CHAR_START;
    assign store   = take && !stray && cnt_eff < CNT_W'(BODY_LEN);
    assign full    = take && cnt_eff == CNT_W'(BODY_LEN);

    always_comb
    begin
        frame_count_next = '0;
        if (store)
        begin
            frame_count_next = cnt_eff + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            last_time_reg   <= '0;
        end
        else if (advance)
        begin
            frame_count_reg <= frame_count_next;
            last_time_reg   <= time_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BODY_LEN; i++)
        begin
            if (advance && store && cnt_eff == CNT_W'(i))
            begin
                bytes_reg[i] <= byte_in;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < BODY_LEN; i++)
        begin
            body[i] = bytes_reg[i];
        end
    end

    assign status.stray     = advance && stray;
    assign status.full      = advance && full;
    assign status.last_byte = byte_in;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg <= CNT_W'(BODY_LEN))
        else $error("frame count beyond body length");

endmodule

// ----- rtl/core/scfd_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_match
// Frame decode: fixed command match, volume parse and handler gating.
// ----------------------------------------------------------------------------
module scfd_match
    import scfd_pkg::*;
(
    input  frame_status_t     status,
    input  frame_body_t       body,
    input  logic [VOL_W-1:0]  vol_floor,
    input  logic [VOL_W-1:0]  vol_ceil,
    input  logic [MASK_W-1:0] handler_mask,
    output event_t            ev
);

    frame_text_t      text;
    logic             cmd_hit;
    logic [3:0]       cmd_idx;
    logic             vol_form;
    logic [3:0]       d1;
    logic [3:0]       d2;
    logic [3:0]       d3;
    logic [VOL_W-1:0] value;
    logic             vol_up;
    logic             vol_down;
    event_kind_t      unk_kind;

    always_comb
    begin
        for (int i = 0; i < BODY_LEN; i++)
        begin
            text[(FRAME_LEN-1-i)*8 +: 8] = body[i];
        end
        text[7:0] = status.last_byte;
    end

    always_comb
    begin
        cmd_hit = 1'b0;
        cmd_idx = '0;
        for (int k = NUM_FIXED - 1; k >= 0; k--)
        begin
            if (text == FIXED_CMDS[k])
            begin
                cmd_hit = 1'b1;
                cmd_idx = 4'(k);
            end
        end
    end

    assign vol_form = text[FRAME_LEN*8-1 -: 32] == VOL_HEAD
                      && (text[23:16] == CHAR_SPACE || is_digit(text[23:16]))
                      && is_digit(text[15:8]) && is_digit(status.last_byte);
    assign d1       = (text[23:16] == CHAR_SPACE) ? 4'd0 : 4'(text[23:16] - CHAR_ZERO);
    assign d2       = 4'(text[15:8] - CHAR_ZERO);
    assign d3       = 4'(status.last_byte - CHAR_ZERO);
    assign value    = VOL_W'(d1) * VOL_W'(100) + VOL_W'(d2) * VOL_W'(10) + VOL_W'(d3);
    assign vol_up   = vol_form && value >= vol_floor && value <= vol_ceil
                      && handler_mask[BIT_VOL_UP];
    assign vol_down = vol_form && value >= VOL_DOWN_LOW && handler_mask[BIT_VOL_DOWN];
    assign unk_kind = handler_mask[BIT_UNKNOWN] ? EV_UNKNOWN : EV_UNKNOWN_NO_H;

    always_comb
    begin
        ev.valid = status.stray || status.full;
        ev.kind  = unk_kind;
        ev.index = '0;
        ev.level = '0;
        if (status.full)
        begin
            if (cmd_hit)
            begin
                ev.kind  = handler_mask[cmd_idx] ? EV_CMD : EV_CMD_NO_HDLR;
                ev.index = cmd_idx;
            end
            else if (vol_up)
            begin
                ev.kind  = EV_VOL_UP;
                ev.level = value;
            end
            else if (vol_down)
            begin
                ev.kind  = EV_VOL_DOWN;
                ev.level = value - VOL_DOWN_OFS;
            end
        end
    end

endmodule

// ----- rtl/core/serial_command_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_decoder
// Builds seven-character command frames from received bytes and reports
// command, volume and unknown events.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | byte_in, time_ms
//  out     | out_valid/out_ready | event_kind, command_index, volume_level
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// One word per cycle unless a held result stalls the input; an accepted word
// passes through the input register and then, if it yields a result, the result register.
// The input register advances into the decode logic whenever the result
// register is empty or being taken; a stalled result holds one word in the
// input register and then drops in_ready.
// Reset clears the frame count, last tick and valid flags and loads the
// register defaults.
// ----------------------------------------------------------------------------
module serial_command_frame_decoder
    import scfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            byte_in,
    input  logic [31:0]           time_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            event_kind,
    output logic [3:0]            command_index,
    output logic [VOL_W-1:0]      volume_level,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              enable_reg;
    logic [31:0]       idle_timeout_reg;
    logic [VOL_W-1:0]  vol_floor_reg;
    logic [VOL_W-1:0]  vol_ceil_reg;
    logic [MASK_W-1:0] handler_mask_reg;

    logic              stage_valid_reg;
    logic [7:0]        stage_byte_reg;
    logic [31:0]       stage_time_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    event_kind_t       kind_reg;
    logic [3:0]        index_reg;
    logic [VOL_W-1:0]  level_reg;

    logic              advance;
    frame_status_t     status;
    frame_body_t       body;
    event_t            ev;

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
            vol_floor_reg    <= VOL_FLOOR_RST;
            vol_ceil_reg     <= VOL_CEIL_RST;
            handler_mask_reg <= HANDLER_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:       enable_reg       <= cfg_data[0];
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                CFG_VOL_FLOOR:    vol_floor_reg    <= cfg_data[VOL_W-1:0];
                CFG_VOL_CEIL:     vol_ceil_reg     <= cfg_data[VOL_W-1:0];
                CFG_HANDLER_MASK: handler_mask_reg <= cfg_data[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_byte_reg <= byte_in;
            stage_time_reg <= time_ms;
        end
    end

    scfd_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .byte_in      (stage_byte_reg),
        .time_ms      (stage_time_reg),
        .enable       (enable_reg),
        .idle_timeout (idle_timeout_reg),
        .status       (status),
        .body         (body)
    );

    scfd_match u_match (
        .status       (status),
        .body         (body),
        .vol_floor    (vol_floor_reg),
        .vol_ceil     (vol_ceil_reg),
        .handler_mask (handler_mask_reg),
        .ev           (ev)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ev.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev.valid)
        begin
            kind_reg  <= ev.kind;
            index_reg <= ev.index;
            level_reg <= ev.level;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign command_index = index_reg;
    assign volume_level  = level_reg;

    a_result_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ev.valid |-> (!out_valid_reg || out_ready))
        else $error("result produced while output register is held");

    a_index_only_for_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_reg != EV_CMD && kind_reg != EV_CMD_NO_HDLR
        |-> command_index == '0)
        else $error("command index set on a non-command event");

    a_level_only_for_vol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind_reg != EV_VOL_UP && kind_reg != EV_VOL_DOWN
        |-> volume_level == '0)
        else $error("volume level set on a non-volume event");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> stage_valid_reg)
        else $error("accepted word lost before decode");

endmodule
